// File: rtl/core/sspq_pkg.sv
// Shared types, constants and a helper function of the stable sorted priority queue.
`timescale 1ns / 1ps

package sspq_pkg;

    localparam int DEPTH  = 64;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int HDL_W  = 16;
    localparam int PRIO_W = 32;
    localparam int OP_W   = 3;
    localparam int STS_W  = 2;
    localparam int OCNT_W = 7;

    localparam logic [OP_W-1:0] OP_INS_AFTER  = 3'd0;
    localparam logic [OP_W-1:0] OP_INS_BEFORE = 3'd1;
    localparam logic [OP_W-1:0] OP_POP_HEAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_POP_TAIL   = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND       = 3'd4;
    localparam logic [OP_W-1:0] OP_REMOVE     = 3'd5;

    localparam logic [STS_W-1:0] STS_OK       = 2'd0;
    localparam logic [STS_W-1:0] STS_EMPTY    = 2'd1;
    localparam logic [STS_W-1:0] STS_FULL     = 2'd2;
    localparam logic [STS_W-1:0] STS_NOTFOUND = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CMP,
        S_COMMIT
    } t_state;

    // What a cell loads at the commit edge.
    typedef enum logic [1:0] {
        MV_KEEP,
        MV_LEFT,
        MV_RIGHT,
        MV_NEW
    } t_move;

    typedef struct packed {
        logic            cmp_en;
        logic [OP_W-1:0] op;
        t_move           move;
    } t_cell_ctl;

    // Bit i is set when any bit below i is set in v (log-depth prefix OR).
    function automatic logic [DEPTH-1:0] prefix_or_below(input logic [DEPTH-1:0] v);
        logic [DEPTH-1:0] x;
        x = v << 1;
        for (int k = 1; k < DEPTH; k = k * 2) begin
            x = x | (x << k);
        end
        return x;
    endfunction

endpackage

// File: rtl/core/sspq_cell.sv
// One storage cell of the sorted chain: holds an entry, compares it, and shifts with neighbors.
`timescale 1ns / 1ps

module sspq_cell
    import sspq_pkg::*;
(
    input  logic              i_clk,
    input  t_cell_ctl         i_ctl,
    input  logic [HDL_W-1:0]  i_req_handle,
    input  logic [PRIO_W-1:0] i_req_prio,
    input  logic [HDL_W-1:0]  i_left_handle,
    input  logic [PRIO_W-1:0] i_left_prio,
    input  logic [HDL_W-1:0]  i_right_handle,
    input  logic [PRIO_W-1:0] i_right_prio,
    output logic [HDL_W-1:0]  o_handle,
    output logic [PRIO_W-1:0] o_prio,
    output logic              o_flag
);

    logic [HDL_W-1:0]  r_handle;
    logic [PRIO_W-1:0] r_prio;
    logic              r_flag;
    logic              n_flag;

    // The flag means "shifts right" for inserts and "matches" for find and remove.
    always_comb begin
        unique case (i_ctl.op)
            OP_INS_AFTER:  n_flag = (r_prio > i_req_prio);
            OP_INS_BEFORE: n_flag = (r_prio >= i_req_prio);
            OP_FIND:       n_flag = (r_prio == i_req_prio);
            OP_REMOVE:     n_flag = (r_handle == i_req_handle);
            default:       n_flag = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp_en) begin
            r_flag <= n_flag;
        end
        unique case (i_ctl.move)
            MV_KEEP: begin
            end
            MV_LEFT: begin
                r_handle <= i_left_handle;
                r_prio   <= i_left_prio;
            end
            MV_RIGHT: begin
                r_handle <= i_right_handle;
                r_prio   <= i_right_prio;
            end
            MV_NEW: begin
                r_handle <= i_req_handle;
                r_prio   <= i_req_prio;
            end
        endcase
    end

    assign o_handle = r_handle;
    assign o_prio   = r_prio;
    assign o_flag   = r_flag;

endmodule

// File: rtl/core/stable_sorted_priority_queue_top.sv
// Top level of the stable sorted priority queue: request handshake, control and result register.
`timescale 1ns / 1ps

// Keeps up to DEPTH (handle, priority) entries sorted by ascending priority in a
// chain of cells; entries of equal priority never change their relative order.
// Input channel (s_axis): tuser carries the operation (insert after equals,
// insert before equals, pop head, pop tail, find priority, remove handle),
// tdata the handle and the priority. Each transfer in gives exactly one
// transfer out (m_axis): tuser carries the status, tdata the handle, the
// priority and the entry count after the operation.
// Every item passes the accept edge, an edge at which all cells compare their
// entry against the request in parallel, and the commit edge at which the
// cells shift and the result register loads. The next item is taken only
// after the commit, so the block never works on two items at once.
// The input may be accepted while a result still waits in the output
// register; if the receiver stalls, the commit waits until that register is
// taken, and the queue contents do not change until then.
// Reset clears the entry count and the handshake state; no clearing pass is
// needed, since only cells below the count are ever read.
module stable_sorted_priority_queue_top
    import sspq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [47:0] i_s_axis_tdata,   // [15:0] handle, [47:16] priority_req
    input  logic [2:0]  i_s_axis_tuser,   // [2:0] operation
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [55:0] o_m_axis_tdata,   // [15:0] handle_out, [47:16] priority_out,
                                          // [54:48] count, [55] zero
    output logic [1:0]  o_m_axis_tuser    // [1:0] status
);

    t_state             r_state;
    t_state             n_state;
    logic [OP_W-1:0]    r_op;
    logic [HDL_W-1:0]   r_req_handle;
    logic [PRIO_W-1:0]  r_req_prio;
    logic [CNT_W-1:0]   r_count;
    logic [CNT_W-1:0]   n_count;
    logic               r_m_valid;
    logic [55:0]        r_m_data;
    logic [STS_W-1:0]   r_m_user;

    logic               s_accept;
    logic               cmp_en;
    logic               commit_en;

    logic [HDL_W-1:0]   w_handle [DEPTH];
    logic [PRIO_W-1:0]  w_prio   [DEPTH];
    logic [HDL_W-1:0]   w_left_handle  [DEPTH];
    logic [PRIO_W-1:0]  w_left_prio    [DEPTH];
    logic [HDL_W-1:0]   w_right_handle [DEPTH];
    logic [PRIO_W-1:0]  w_right_prio   [DEPTH];
    t_cell_ctl          w_ctl [DEPTH];
    logic [DEPTH-1:0]   w_flag;
    logic [DEPTH-1:0]   occ;
    logic [DEPTH-1:0]   shift_r;
    logic [DEPTH-1:0]   hit;
    logic [DEPTH-1:0]   hit_before;
    logic [DEPTH-1:0]   sel;
    logic               is_insert;
    logic               ins_ok;
    logic               q_empty;
    logic               found;
    logic [HDL_W-1:0]   sel_handle;
    logic [PRIO_W-1:0]  sel_prio;
    logic [STS_W-1:0]   res_status;
    logic [HDL_W-1:0]   res_handle;
    logic [PRIO_W-1:0]  res_prio;
    t_move              move [DEPTH];

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:   if (i_s_axis_tvalid) n_state = S_CMP;
            S_CMP:    n_state = S_COMMIT;
            S_COMMIT: if (!r_m_valid || i_m_axis_tready) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // State outputs.
    always_comb begin
        o_s_axis_tready = 1'b0;
        cmp_en          = 1'b0;
        commit_en       = 1'b0;
        unique case (r_state)
            S_IDLE:   o_s_axis_tready = 1'b1;
            S_CMP:    cmp_en = 1'b1;
            S_COMMIT: commit_en = !r_m_valid || i_m_axis_tready;
            default: begin
            end
        endcase
    end

    assign s_accept = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_count   <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (commit_en) begin
                r_count   <= n_count;
                r_m_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_op         <= i_s_axis_tuser;
            r_req_handle <= i_s_axis_tdata[15:0];
            r_req_prio   <= i_s_axis_tdata[47:16];
        end
        if (commit_en) begin
            r_m_data <= {1'b0, OCNT_W'(n_count), res_prio, res_handle};
            r_m_user <= res_status;
        end
    end

    // Occupancy and selection vectors over the chain.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            occ[i] = (CNT_W'(i) < r_count);
        end
        shift_r    = ~occ | w_flag;
        hit        = occ & w_flag;
        hit_before = prefix_or_below(hit);
        found      = |hit;
        q_empty    = (r_count == '0);
        is_insert  = (r_op == OP_INS_AFTER) || (r_op == OP_INS_BEFORE);
        ins_ok     = is_insert && (r_count < CNT_W'(DEPTH));
        sel        = '0;
        if (r_op == OP_POP_HEAD) begin
            sel[0] = !q_empty;
        end else if (r_op == OP_POP_TAIL) begin
            sel = occ & ~(occ >> 1);
        end else if ((r_op == OP_FIND) || (r_op == OP_REMOVE)) begin
            sel = hit & ~hit_before;
        end
    end

    always_comb begin
        sel_handle = '0;
        sel_prio   = '0;
        for (int i = 0; i < DEPTH; i++) begin
            sel_handle = sel_handle | (w_handle[i] & {HDL_W{sel[i]}});
            sel_prio   = sel_prio   | (w_prio[i]   & {PRIO_W{sel[i]}});
        end
    end

    // Result and new count.
    always_comb begin
        res_status = STS_OK;
        res_handle = '0;
        res_prio   = '0;
        n_count    = r_count;
        priority if (is_insert) begin
            if (ins_ok) begin
                res_handle = r_req_handle;
                res_prio   = r_req_prio;
                n_count    = r_count + CNT_W'(1);
            end else begin
                res_status = STS_FULL;
            end
        end else if ((r_op == OP_POP_HEAD) || (r_op == OP_POP_TAIL)) begin
            if (q_empty) begin
                res_status = STS_EMPTY;
            end else begin
                res_handle = sel_handle;
                res_prio   = sel_prio;
                n_count    = r_count - CNT_W'(1);
            end
        end else if ((r_op == OP_FIND) || (r_op == OP_REMOVE)) begin
            if (found) begin
                res_handle = sel_handle;
                res_prio   = sel_prio;
                if (r_op == OP_REMOVE) begin
                    n_count = r_count - CNT_W'(1);
                end
            end else begin
                res_status = STS_NOTFOUND;
            end
        end else begin
            // Unused operation codes leave the queue alone and report ok.
        end
    end

    // Per-cell moves at the commit edge.
    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            move[i] = MV_KEEP;
            if (commit_en) begin
                if (ins_ok) begin
                    if ((i > 0) && shift_r[(i > 0) ? i - 1 : 0]) begin
                        move[i] = MV_LEFT;
                    end else if (shift_r[i]) begin
                        move[i] = MV_NEW;
                    end
                end else if ((r_op == OP_POP_HEAD) && !q_empty && (i < DEPTH - 1)) begin
                    move[i] = MV_RIGHT;
                end else if ((r_op == OP_REMOVE) && (hit[i] || hit_before[i])
                             && (i < DEPTH - 1)) begin
                    move[i] = MV_RIGHT;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_ctl[i].cmp_en = cmp_en;
            w_ctl[i].op     = r_op;
            w_ctl[i].move   = move[i];
            w_left_handle[i]  = (i > 0) ? w_handle[(i > 0) ? i - 1 : 0] : '0;
            w_left_prio[i]    = (i > 0) ? w_prio[(i > 0) ? i - 1 : 0] : '0;
            w_right_handle[i] = (i < DEPTH - 1) ? w_handle[(i < DEPTH - 1) ? i + 1 : i]
                                                : w_handle[i];
            w_right_prio[i]   = (i < DEPTH - 1) ? w_prio[(i < DEPTH - 1) ? i + 1 : i]
                                                : w_prio[i];
        end
    end

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        sspq_cell u_cell (
            .i_clk          (i_clk),
            .i_ctl          (w_ctl[g]),
            .i_req_handle   (r_req_handle),
            .i_req_prio     (r_req_prio),
            .i_left_handle  (w_left_handle[g]),
            .i_left_prio    (w_left_prio[g]),
            .i_right_handle (w_right_handle[g]),
            .i_right_prio   (w_right_prio[g]),
            .o_handle       (w_handle[g]),
            .o_prio         (w_prio[g]),
            .o_flag         (w_flag[g])
        );
    end

    assign o_m_axis_tvalid = r_m_valid;
    assign o_m_axis_tdata  = r_m_data;
    assign o_m_axis_tuser  = r_m_user;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_insert_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_en && ins_ok |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("successful insert did not add one entry");

    a_sel_onehot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        commit_en |-> $onehot0(sel))
        else $error("more than one cell selected for the result");

endmodule

// File: test/tb_stable_sorted_priority_queue_top.sv
// Self-checking testbench for the stable sorted priority queue top level.
`timescale 1ns / 1ps

module tb_stable_sorted_priority_queue_top;
    import sspq_pkg::*;

    // Operation codes the block does not define; it must leave the queue untouched and report ok.
    localparam logic [OP_W-1:0] OP_RSVD_A = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD_B = 3'd7;

    localparam int TIMEOUT_NS  = 400_000;
    localparam int PHASE_ITEMS = 40;
    localparam int SETTLE_CYC  = 10;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [HDL_W-1:0]  handle;
        logic [PRIO_W-1:0] prio;
    } t_request;

    typedef struct packed {
        logic [STS_W-1:0]  status;
        logic [HDL_W-1:0]  handle;
        logic [PRIO_W-1:0] prio;
        logic [OCNT_W-1:0] count;
    } t_outcome;

    typedef struct packed {
        t_request req;
        logic     known;
        t_outcome outcome;
    } t_row;

    localparam int N_SMOKE = 25;

    // Rows with the known flag set carry their result; the rest go through the predictor.
    localparam t_row SMOKE_ROWS [N_SMOKE] = '{
        {OP_POP_HEAD,   16'h0000, 32'h0000_0000, 1'b1, STS_EMPTY,    16'h0000, 32'h0, 7'd0},
        {OP_POP_TAIL,   16'hFFFF, 32'hFFFF_FFFF, 1'b1, STS_EMPTY,    16'h0000, 32'h0, 7'd0},
        {OP_FIND,       16'h0000, 32'hFFFF_FFFF, 1'b1, STS_NOTFOUND, 16'h0000, 32'h0, 7'd0},
        {OP_REMOVE,     16'hFFFF, 32'h0000_0000, 1'b1, STS_NOTFOUND, 16'h0000, 32'h0, 7'd0},
        {OP_RSVD_A,     16'hFFFF, 32'hFFFF_FFFF, 1'b1, STS_OK,       16'h0000, 32'h0, 7'd0},
        {OP_INS_AFTER,  16'hFFFF, 32'hFFFF_FFFF, 1'b1, STS_OK, 16'hFFFF, 32'hFFFF_FFFF, 7'd1},
        {OP_INS_BEFORE, 16'h0000, 32'h0000_0000, 1'b1, STS_OK, 16'h0000, 32'h0000_0000, 7'd2},
        {OP_RSVD_B,     16'h1234, 32'h0000_0005, 1'b1, STS_OK,       16'h0000, 32'h0, 7'd2},
        {OP_INS_AFTER,  16'h0011, 32'd100,       1'b0, 57'd0},
        {OP_INS_AFTER,  16'h0022, 32'd100,       1'b0, 57'd0},
        {OP_INS_BEFORE, 16'h0033, 32'd100,       1'b0, 57'd0},
        {OP_FIND,       16'h0000, 32'd100,       1'b0, 57'd0},
        {OP_INS_AFTER,  16'h0011, 32'd50,        1'b0, 57'd0},
        {OP_REMOVE,     16'h0011, 32'd0,         1'b0, 57'd0},
        {OP_FIND,       16'h0000, 32'd100,       1'b0, 57'd0},
        {OP_REMOVE,     16'h0033, 32'd0,         1'b0, 57'd0},
        {OP_FIND,       16'h0000, 32'd100,       1'b0, 57'd0},
        {OP_FIND,       16'h0000, 32'd7,         1'b0, 57'd0},
        {OP_POP_TAIL,   16'h0000, 32'd0,         1'b0, 57'd0},
        {OP_POP_HEAD,   16'h0000, 32'd0,         1'b0, 57'd0},
        {OP_INS_BEFORE, 16'hAAAA, 32'h8000_0000, 1'b0, 57'd0},
        {OP_POP_TAIL,   16'h0000, 32'd0,         1'b0, 57'd0},
        {OP_POP_HEAD,   16'h0000, 32'd0,         1'b0, 57'd0},
        {OP_POP_HEAD,   16'h0000, 32'd0,         1'b0, 57'd0},
        {OP_REMOVE,     16'h0022, 32'd0,         1'b1, STS_NOTFOUND, 16'h0000, 32'h0, 7'd0}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    logic        o_s_axis_tready;
    logic [47:0] i_s_axis_tdata = '0;   // [15:0] handle, [47:16] priority_req
    logic [2:0]  i_s_axis_tuser = '0;   // [2:0] operation
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    logic [55:0] o_m_axis_tdata;        // [15:0] handle_out, [47:16] priority_out,
                                        // [54:48] count, [55] zero
    logic [1:0]  o_m_axis_tuser;        // [1:0] status

    // Shadow copy of the queue contents, kept sorted like the block's cells.
    logic [HDL_W-1:0]  held_handles    [DEPTH];
    logic [PRIO_W-1:0] held_priorities [DEPTH];
    int                held_count = 0;

    t_outcome pending_results [$];
    int       mismatches = 0;
    int       real_items_sent = 0;
    int       sender_idle_pct = 0;
    int       recv_stall_pct = 0;

    stable_sorted_priority_queue_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Applies one request to the shadow queue and returns the result the block must give.
    function automatic t_outcome apply_queue_op(t_request req);
        t_outcome res;
        int       pos;
        int       k;
        int       victim;
        res = '0;
        res.status = STS_OK;
        victim = -1;
        case (req.op)
            OP_INS_AFTER, OP_INS_BEFORE: begin
                if (held_count >= DEPTH) begin
                    res.status = STS_FULL;
                end else begin
                    pos = 0;
                    while (pos < held_count && (held_priorities[pos] < req.prio ||
                           (req.op == OP_INS_AFTER && held_priorities[pos] == req.prio)))
                        pos++;
                    for (k = held_count; k > pos; k--) begin
                        held_handles[k]    = held_handles[k-1];
                        held_priorities[k] = held_priorities[k-1];
                    end
                    held_handles[pos]    = req.handle;
                    held_priorities[pos] = req.prio;
                    held_count++;
                    res.handle = req.handle;
                    res.prio   = req.prio;
                end
            end
            OP_POP_HEAD, OP_POP_TAIL: begin
                if (held_count == 0)
                    res.status = STS_EMPTY;
                else
                    victim = (req.op == OP_POP_HEAD) ? 0 : held_count - 1;
            end
            OP_FIND, OP_REMOVE: begin
                res.status = STS_NOTFOUND;
                for (k = 0; k < held_count; k++) begin
                    if (pos < 0 || k == 0)
                        pos = -1;
                    if (victim < 0 && res.status == STS_NOTFOUND &&
                        ((req.op == OP_FIND) ? held_priorities[k] == req.prio
                                             : held_handles[k] == req.handle)) begin
                        res.status = STS_OK;
                        res.handle = held_handles[k];
                        res.prio   = held_priorities[k];
                        if (req.op == OP_REMOVE)
                            victim = k;
                    end
                end
            end
            default: ;
        endcase
        if (victim >= 0) begin
            res.handle = held_handles[victim];
            res.prio   = held_priorities[victim];
            for (k = victim; k < held_count - 1; k++) begin
                held_handles[k]    = held_handles[k+1];
                held_priorities[k] = held_priorities[k+1];
            end
            held_count--;
        end
        res.count = held_count[OCNT_W-1:0];
        return res;
    endfunction

    // Random request: mostly inserts, pops and hits on held entries, plus some noise.
    function automatic t_request pick_request(int grow_pct, int noise_pct);
        t_request req;
        int       roll;
        int       idx;
        req.handle = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(31));
        roll = $urandom_range(99);
        if (roll < 50) begin
            req.prio = 32'($urandom_range(15));
        end else if (roll < 65) begin
            case ($urandom_range(3))
                0:       req.prio = 32'h0000_0000;
                1:       req.prio = 32'hFFFF_FFFF;
                2:       req.prio = 32'h8000_0000;
                default: req.prio = 32'h7FFF_FFFF;
            endcase
        end else begin
            req.prio = $urandom;
        end
        if ($urandom_range(99) < noise_pct) begin
            case ($urandom_range(3))
                0:       req.op = OP_RSVD_A;
                1:       req.op = OP_RSVD_B;
                2:       req.op = OP_FIND;
                default: req.op = OP_REMOVE;
            endcase
        end else if ($urandom_range(99) < grow_pct) begin
            req.op = $urandom_range(1) ? OP_INS_AFTER : OP_INS_BEFORE;
        end else begin
            case ($urandom_range(3))
                0:       req.op = OP_POP_HEAD;
                1:       req.op = OP_POP_TAIL;
                2:       req.op = OP_FIND;
                default: req.op = OP_REMOVE;
            endcase
            if ((req.op == OP_FIND || req.op == OP_REMOVE) && held_count > 0) begin
                idx = $urandom_range(held_count - 1);
                req.handle = held_handles[idx];
                req.prio   = held_priorities[idx];
            end
        end
        return req;
    endfunction

    // Drives one request and returns at the edge where it is transferred.
    task automatic send_request(t_request req, logic known, t_outcome known_res);
        t_outcome want;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < sender_idle_pct);
        end
        want = apply_queue_op(req);
        pending_results.push_back(known ? known_res : want);
        if (req.op <= OP_REMOVE)
            real_items_sent++;
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {req.prio, req.handle};
        i_s_axis_tuser  <= req.op;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // The valid is dropped first so the last request is not taken a second time while results drain.
    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_outcome want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with nothing outstanding");
                mismatches++;
            end else begin
                want = pending_results.pop_front();
                if (o_m_axis_tuser !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_m_axis_tuser);
                    mismatches++;
                end
                if (o_m_axis_tdata[15:0] !== want.handle) begin
                    $error("handle_out: expected %h, actual %h",
                           want.handle, o_m_axis_tdata[15:0]);
                    mismatches++;
                end
                if (o_m_axis_tdata[47:16] !== want.prio) begin
                    $error("priority_out: expected %h, actual %h",
                           want.prio, o_m_axis_tdata[47:16]);
                    mismatches++;
                end
                if (o_m_axis_tdata[54:48] !== want.count) begin
                    $error("count: expected %0d, actual %0d", want.count, o_m_axis_tdata[54:48]);
                    mismatches++;
                end
            end
        end
        i_m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        t_request req;
        int       phase;
        int       phase_start;
        int       burst_len;
        int       grow_pct;
        int       extra;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (SMOKE_ROWS[r])
            send_request(SMOKE_ROWS[r].req, SMOKE_ROWS[r].known, SMOKE_ROWS[r].outcome);

        for (phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin sender_idle_pct = 84; recv_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  recv_stall_pct = 84; end
                default: begin sender_idle_pct = 12; recv_stall_pct = 12; end
            endcase
            // Fill to the brim and push a few more inserts into the full queue.
            if (phase % 2 == 0) begin
                while (held_count < DEPTH)
                    send_request(pick_request(100, 0), 1'b0, '0);
                for (extra = 0; extra < 3; extra++)
                    send_request(pick_request(100, 0), 1'b0, '0);
            end
            phase_start = real_items_sent;
            while (real_items_sent - phase_start < PHASE_ITEMS) begin
                burst_len = $urandom_range(8, 30);
                case ($urandom_range(2))
                    0:       grow_pct = 25;
                    1:       grow_pct = 50;
                    default: grow_pct = 75;
                endcase
                repeat (burst_len)
                    send_request(pick_request(grow_pct, 10), 1'b0, '0);
            end
            if (phase % 2 == 1) begin
                while (held_count > 0) begin
                    req = pick_request(0, 0);
                    req.op = $urandom_range(1) ? OP_POP_HEAD : OP_POP_TAIL;
                    send_request(req, 1'b0, '0);
                end
                req.op = OP_POP_TAIL;
                send_request(req, 1'b0, '0);
            end
            // Hold the sender off until the block has handed back everything.
            drain_results();
        end

        drain_results();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (mismatches == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        #TIMEOUT_NS;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule
